@@ hdl/obsf_pkg.sv @@
// ----------------------------------------------------------------------------
// Order book sweep fill package
// Shared field widths, stream packing widths, function codes and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package obsf_pkg;

   // Default number of price levels kept on each side of the book.
   localparam int BOOK_LEVELS_DEF = 16;

   // Field widths.
   localparam int FUNC_W  = 2;
   localparam int INDEX_W = 5;
   localparam int PRICE_W = 32;
   localparam int QTY_W   = 31;
   localparam int ID_W    = 32;
   localparam int SYM_W   = 16;
   localparam int FQTY_W  = 32;
   localparam int TIME_W  = 64;

   // Stream widths, padded to whole bytes.
   localparam int REQ_DATA_W = 280;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 176;
   localparam int RSP_USER_W = 1;

   // Input item function codes.
   typedef enum logic [FUNC_W-1:0] {
      FUNC_WRITE = 2'd0,
      FUNC_DEPTH = 2'd1,
      FUNC_EXEC  = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic write_level;
      logic set_depth;
      logic load_order;
      logic advance;
      logic push_hold;
      logic flush;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic walk_end;
      logic level_fill;
      logic level_final;
      logic hold_valid;
      logic out_free;
   } dp_status_type;

endpackage

@@ hdl/obsf_ram.sv @@
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read data output.
// ----------------------------------------------------------------------------
module obsf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/obsf_datapath.sv @@
// ----------------------------------------------------------------------------
// Order book sweep fill datapath
// Holds the book memory, side depths, the latched order, the walk position,
// the pending fill and the result output register.
// ----------------------------------------------------------------------------
module obsf_datapath #(
   parameter int BOOK_LEVELS = obsf_pkg::BOOK_LEVELS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  obsf_pkg::dp_cmd_type            cmd,
   output obsf_pkg::dp_status_type         st,
   input  logic                            req_side,
   input  logic [obsf_pkg::INDEX_W-1:0]    req_level_index,
   input  logic [obsf_pkg::PRICE_W-1:0]    req_level_price,
   input  logic [obsf_pkg::QTY_W-1:0]      req_level_qty,
   input  logic [obsf_pkg::ID_W-1:0]       req_ord_num,
   input  logic [obsf_pkg::SYM_W-1:0]      req_symbol_id,
   input  logic [obsf_pkg::QTY_W-1:0]      req_order_qty,
   input  logic                            req_is_limit,
   input  logic [obsf_pkg::PRICE_W-1:0]    req_lim_price,
   input  logic [obsf_pkg::PRICE_W-1:0]    req_ref_price,
   input  logic [obsf_pkg::TIME_W-1:0]     req_time_stamp,
   input  logic                            rsp_tready,
   output logic                            rsp_tvalid,
   output logic                            rsp_fill_valid,
   output logic [obsf_pkg::ID_W-1:0]       rsp_fill_ord_num,
   output logic [obsf_pkg::SYM_W-1:0]      rsp_fill_symbol,
   output logic signed [obsf_pkg::FQTY_W-1:0] rsp_fill_qty,
   output logic [obsf_pkg::PRICE_W-1:0]    rsp_fill_price,
   output logic [obsf_pkg::TIME_W-1:0]     rsp_fill_time,
   output logic                            rsp_last
);

   localparam int LVL_AW    = (BOOK_LEVELS > 1) ? $clog2(BOOK_LEVELS) : 1;
   localparam int DEPTH_W   = $clog2(BOOK_LEVELS + 1);
   localparam int RAM_AW    = LVL_AW + 1;
   localparam int RAM_DEPTH = 2 ** RAM_AW;
   localparam int RAM_W     = obsf_pkg::PRICE_W + obsf_pkg::QTY_W;

   // Book memory signals.
   logic              wr_en;
   logic [RAM_AW-1:0] wr_addr;
   logic              rd_en;
   logic [RAM_AW-1:0] rd_addr;
   logic [RAM_W-1:0]  rd_data;

   // Side depths.
   logic [DEPTH_W-1:0] ask_depth_ff;
   logic [DEPTH_W-1:0] bid_depth_ff;
   logic [DEPTH_W-1:0] depth_in;
   logic [DEPTH_W-1:0] cur_depth;

   // Latched order.
   logic                         side_ff;
   logic                         limit_ff;
   logic [obsf_pkg::PRICE_W-1:0] lim_ff;
   logic [obsf_pkg::PRICE_W-1:0] refp_ff;
   logic [obsf_pkg::ID_W-1:0]    oid_ff;
   logic [obsf_pkg::SYM_W-1:0]   sym_ff;
   logic [obsf_pkg::TIME_W-1:0]  ts_ff;
   logic [obsf_pkg::QTY_W-1:0]   rem_ff;
   logic [DEPTH_W-1:0]           pos_ff;
   logic [DEPTH_W-1:0]           pos_in;

   // Current level evaluation.
   logic [obsf_pkg::PRICE_W-1:0] lvl_price;
   logic [obsf_pkg::QTY_W-1:0]   lvl_qty;
   logic                         past_limit;
   logic [obsf_pkg::QTY_W-1:0]   take;
   logic [obsf_pkg::FQTY_W-1:0]  take_ext;
   logic [obsf_pkg::FQTY_W-1:0]  fill_qty;
   logic [obsf_pkg::PRICE_W-1:0] fill_price;

   // Pending fill, held until the next fill or the end of the walk.
   logic                         hold_valid_ff;
   logic                         hold_valid_in;
   logic [obsf_pkg::FQTY_W-1:0]  hold_qty_ff;
   logic [obsf_pkg::PRICE_W-1:0] hold_price_ff;

   // Output register.
   logic                         out_valid_ff;
   logic                         out_valid_in;
   logic                         out_fill_valid_ff;
   logic                         out_last_ff;
   logic [obsf_pkg::ID_W-1:0]    out_oid_ff;
   logic [obsf_pkg::SYM_W-1:0]   out_sym_ff;
   logic [obsf_pkg::FQTY_W-1:0]  out_qty_ff;
   logic [obsf_pkg::PRICE_W-1:0] out_price_ff;
   logic [obsf_pkg::TIME_W-1:0]  out_time_ff;

   // Level writes land only inside the book; side sits in the top address bit.
   assign wr_en   = cmd.write_level &&
                    (32'(req_level_index) < 32'(BOOK_LEVELS));
   assign wr_addr = {req_side, LVL_AW'(req_level_index)};

   // The first level is read as the order is taken, the next one on each step.
   assign pos_in  = pos_ff + DEPTH_W'(1);
   assign rd_en   = cmd.load_order || cmd.advance;
   assign rd_addr = cmd.load_order ? {req_side, LVL_AW'(0)}
                                   : {side_ff, pos_in[LVL_AW-1:0]};

   obsf_ram #(
      .WIDTH (RAM_W),
      .DEPTH (RAM_DEPTH)
   ) u_book (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({req_level_price, req_level_qty}),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Depth writes saturate at the book size.
   assign depth_in = (32'(req_level_index) > 32'(BOOK_LEVELS)) ? DEPTH_W'(BOOK_LEVELS)
                                                             : DEPTH_W'(req_level_index);

   always_ff @(posedge clock) begin
      if (reset) begin
         ask_depth_ff <= '0;
         bid_depth_ff <= '0;
      end else if (cmd.set_depth) begin
         if (req_side) begin
            bid_depth_ff <= depth_in;
         end else begin
            ask_depth_ff <= depth_in;
         end
      end
   end

   // Level evaluation: limit check, fill size, sign and price.
   assign lvl_price  = rd_data[RAM_W-1:obsf_pkg::QTY_W];
   assign lvl_qty    = rd_data[obsf_pkg::QTY_W-1:0];
   assign cur_depth  = side_ff ? bid_depth_ff : ask_depth_ff;
   assign past_limit = side_ff ? (lvl_price < lim_ff) : (lvl_price > lim_ff);
   assign take       = (lvl_qty < rem_ff) ? lvl_qty : rem_ff;
   assign take_ext   = {1'b0, take};
   assign fill_qty   = side_ff ? (obsf_pkg::FQTY_W'(0) - take_ext) : take_ext;
   assign fill_price = (lvl_price != '0) ? lvl_price : refp_ff;

   assign st.walk_end    = (pos_ff >= cur_depth) || (rem_ff == '0) ||
                           (limit_ff && past_limit);
   assign st.level_fill  = (lvl_qty != '0);
   assign st.level_final = (lvl_qty >= rem_ff);
   assign st.hold_valid  = hold_valid_ff;
   assign st.out_free    = !out_valid_ff || rsp_tready;

   // Order latch and walk state.
   always_ff @(posedge clock) begin
      if (cmd.load_order) begin
         side_ff  <= req_side;
         limit_ff <= req_is_limit;
         lim_ff   <= req_lim_price;
         refp_ff  <= req_ref_price;
         oid_ff   <= req_ord_num;
         sym_ff   <= req_symbol_id;
         ts_ff    <= req_time_stamp;
         rem_ff   <= req_order_qty;
         pos_ff   <= '0;
      end else if (cmd.advance) begin
         pos_ff <= pos_in;
         if (st.level_fill) begin
            rem_ff <= rem_ff - take;
         end
      end
   end

   // Pending fill register.
   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (cmd.advance && st.level_fill) begin
         hold_valid_in = 1'b1;
      end else if (cmd.flush) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.advance && st.level_fill) begin
         hold_qty_ff   <= fill_qty;
         hold_price_ff <= fill_price;
      end
   end

   // Output register: a pushed fill is never the last, a flush always is.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.push_hold || cmd.flush) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push_hold || cmd.flush) begin
         out_oid_ff  <= oid_ff;
         out_sym_ff  <= sym_ff;
         out_time_ff <= ts_ff;
         out_last_ff <= cmd.flush;
         if (cmd.push_hold || hold_valid_ff) begin
            out_fill_valid_ff <= 1'b1;
            out_qty_ff        <= hold_qty_ff;
            out_price_ff      <= hold_price_ff;
         end else begin
            out_fill_valid_ff <= 1'b0;
            out_qty_ff        <= '0;
            out_price_ff      <= '0;
         end
      end
   end

   assign rsp_tvalid        = out_valid_ff;
   assign rsp_fill_valid    = out_fill_valid_ff;
   assign rsp_fill_ord_num  = out_oid_ff;
   assign rsp_fill_symbol   = out_sym_ff;
   assign rsp_fill_qty      = out_qty_ff;
   assign rsp_fill_price    = out_price_ff;
   assign rsp_fill_time     = out_time_ff;
   assign rsp_last          = out_last_ff;

   // A no-fill marker always closes its execute.
   a_marker_last : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_fill_valid_ff |-> out_last_ff)
      else $error("no-fill result without last");

   // A real fill always moves some lots.
   a_fill_nonzero : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_fill_valid_ff |-> (out_qty_ff != '0))
      else $error("fill with zero quantity");

   // A push may only happen into a free output register.
   a_push_free : assert property (@(posedge clock) disable iff (reset)
      (cmd.push_hold || cmd.flush) |-> (!out_valid_ff || rsp_tready))
      else $error("result overwritten before it was taken");

endmodule

@@ hdl/obsf_ctrl.sv @@
// ----------------------------------------------------------------------------
// Order book sweep fill controller
// Decodes input items and sequences the level walk of an execute, stalling
// on the result channel whenever a result cannot be handed over.
// ----------------------------------------------------------------------------
module obsf_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  obsf_pkg::func_type      req_func,
   input  obsf_pkg::dp_status_type st,
   output obsf_pkg::dp_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_WALK  = 3'b010,
      ST_FLUSH = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state and command decode.
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               case (req_func)
                  obsf_pkg::FUNC_WRITE: begin
                     cmd.write_level = 1'b1;
                  end
                  obsf_pkg::FUNC_DEPTH: begin
                     cmd.set_depth = 1'b1;
                  end
                  obsf_pkg::FUNC_EXEC: begin
                     cmd.load_order = 1'b1;
                     state_in       = ST_WALK;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WALK: begin
            if (st.walk_end) begin
               state_in = ST_FLUSH;
            end else if (!st.level_fill) begin
               // Empty level: step over it.
               cmd.advance = 1'b1;
            end else if (!st.hold_valid || st.out_free) begin
               cmd.advance   = 1'b1;
               cmd.push_hold = st.hold_valid;
               if (st.level_final) begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (st.out_free) begin
               cmd.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // No fill is left pending once the block takes new items.
   a_idle_no_hold : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !st.hold_valid)
      else $error("pending fill left behind in idle");

   // A fill that completes the order ends the walk.
   a_final_flush : assert property (@(posedge clock) disable iff (reset)
      cmd.advance && st.level_fill && st.level_final |=> (state_ff == ST_FLUSH))
      else $error("walk continued after the order was filled");

endmodule

@@ hdl/order_book_sweep_fill.sv @@
// ----------------------------------------------------------------------------
// Order book sweep fill
// Price-level order book with a sweeping fill engine. Level-write and
// depth-set items build the ask and bid books; an execute item walks the
// opposite side best first and emits one fill per level it trades against.
//
//   Channel  Direction  Beat contents
//   req_     in         tuser: func; tdata: book write or order fields
//   rsp_     out        tuser: fill_valid; tdata: fill fields; tlast: last
//
// Write, depth-set and unused items are taken back to back while idle. An execute
// latches the order and reads level 0, steps through the levels (at most
// BOOK_LEVELS), sees the walk end and loads the last beat; a level that completes
// the order skips the walk-end step. No new item is taken until the last beat is loaded.
// Reset is synchronous and clears the side depths and all handshake state.
// A stalled result channel holds the walk at the next filled level.
// ----------------------------------------------------------------------------
module order_book_sweep_fill #(
   parameter int BOOK_LEVELS = obsf_pkg::BOOK_LEVELS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // side, level_index, level_price, level_qty, order number, symbol_id,
   // order_qty, is_limit, limit price, reference price, time_stamp, zero pad
   input  logic [obsf_pkg::REQ_DATA_W-1:0]   req_tdata,
   // func
   input  logic [obsf_pkg::REQ_USER_W-1:0]   req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // fill order number, fill_symbol, fill_qty, fill_price, fill_time
   output logic [obsf_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // fill_valid
   output logic [obsf_pkg::RSP_USER_W-1:0]   rsp_tuser,
   output logic                              rsp_tlast
);

   obsf_pkg::dp_cmd_type    cmd;
   obsf_pkg::dp_status_type st;

   logic                              fill_valid;
   logic [obsf_pkg::ID_W-1:0]         fill_ord_num;
   logic [obsf_pkg::SYM_W-1:0]        fill_symbol;
   logic signed [obsf_pkg::FQTY_W-1:0] fill_qty;
   logic [obsf_pkg::PRICE_W-1:0]      fill_price;
   logic [obsf_pkg::TIME_W-1:0]       fill_time;

   // Sequencer.
   obsf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_func   (obsf_pkg::func_type'(req_tuser[1:0])),
      .st         (st),
      .cmd        (cmd)
   );

   // Book, order and result registers.
   obsf_datapath #(
      .BOOK_LEVELS (BOOK_LEVELS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .st                  (st),
      .req_side            (req_tdata[0]),
      .req_level_index     (req_tdata[5:1]),
      .req_level_price     (req_tdata[37:6]),
      .req_level_qty       (req_tdata[68:38]),
      .req_ord_num         (req_tdata[100:69]),
      .req_symbol_id       (req_tdata[116:101]),
      .req_order_qty       (req_tdata[147:117]),
      .req_is_limit        (req_tdata[148]),
      .req_lim_price       (req_tdata[180:149]),
      .req_ref_price       (req_tdata[212:181]),
      .req_time_stamp      (req_tdata[276:213]),
      .rsp_tready          (rsp_tready),
      .rsp_tvalid          (rsp_tvalid),
      .rsp_fill_valid      (fill_valid),
      .rsp_fill_ord_num    (fill_ord_num),
      .rsp_fill_symbol     (fill_symbol),
      .rsp_fill_qty        (fill_qty),
      .rsp_fill_price      (fill_price),
      .rsp_fill_time       (fill_time),
      .rsp_last            (rsp_tlast)
   );

   // Result beat packing, first field in the lowest bits.
   assign rsp_tdata = {fill_time, fill_price, fill_qty, fill_symbol, fill_ord_num};
   assign rsp_tuser = fill_valid;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Order book sweep fill testbench
// Builds ask and bid books with level writes and depth sets, sweeps them
// with market and limit orders, and checks every fill beat field by field
// against a scoreboard copy of the book while both stream sides stall.
// ---------------------------------------------------------------------------
module testbench;

   localparam int LEVELS       = obsf_pkg::BOOK_LEVELS_DEF;
   localparam int RANDOM_ITEMS = 110;
   localparam int HOLD_CYCLES  = 400;

   // One request beat plus the scheduling hints that travel with it.
   typedef struct packed {
      obsf_pkg::func_type func;
      logic        side;
      logic [4:0]  idx;
      logic [31:0] lprice;
      logic [30:0] lqty;
      logic [31:0] oid;
      logic [15:0] sym;
      logic [30:0] oqty;
      logic        is_lim;
      logic [31:0] lim;
      logic [31:0] refp;
      logic [63:0] stamp;
      logic        wait_idle;
      logic [1:0]  phase;
   } book_req_type;

   // One fill beat as it should appear on the result channel.
   typedef struct packed {
      logic        valid;
      logic [31:0] oid;
      logic [15:0] sym;
      logic [31:0] qty;
      logic [31:0] px;
      logic [63:0] stamp;
      logic        last;
   } fill_beat_type;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [obsf_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic [obsf_pkg::REQ_USER_W-1:0] req_tuser  = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [obsf_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [obsf_pkg::RSP_USER_W-1:0] rsp_tuser;
   logic                            rsp_tlast;

   // Stimulus backlog and the fills still owed by the block.
   book_req_type  req_backlog[$];
   book_req_type  in_flight;
   fill_beat_type expected_fills[$];

   // Scoreboard copy of the book.
   logic [31:0] shadow_px   [2][LEVELS];
   logic [30:0] shadow_lots [2][LEVELS];
   int unsigned shadow_depth[2];

   // Generator bookkeeping: which levels hold defined contents.
   logic [LEVELS-1:0] levels_written[2];
   logic [1:0]        gen_phase   = 2'd0;
   logic              drain_next  = 1'b0;
   int                staged_total  = 0;
   int                useful_staged = 0;

   // Run status.
   int          accepted_count = 0;
   int          errors         = 0;
   int          n_exec = 0, n_fills = 0, n_nofill = 0, n_book = 0, n_ignored = 0;
   logic [1:0]  idle_phase = 2'd0;
   int unsigned hold_left  = 0;
   logic        hold_done  = 1'b0;

   order_book_sweep_fill DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // side, level_index, level_price, level_qty, order number,
                                 // symbol_id, order_qty, is_limit, limit price,
                                 // reference price, time_stamp, zero pad
      .req_tuser  (req_tuser),   // func
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // fill order number, fill_symbol, fill_qty, fill_price,
                                 // fill_time
      .rsp_tuser  (rsp_tuser),   // fill_valid
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Every beat field random, func set to the unused code; callers overwrite the ones that matter.
   function automatic book_req_type any_beat();
      book_req_type r;
      r.func      = obsf_pkg::FUNC_NONE;
      r.side      = 1'($urandom);
      r.idx       = 5'($urandom);
      r.lprice    = $urandom;
      r.lqty      = 31'($urandom);
      r.oid       = $urandom;
      r.sym       = 16'($urandom);
      r.oqty      = 31'($urandom);
      r.is_lim    = 1'($urandom);
      r.lim       = $urandom;
      r.refp      = $urandom;
      r.stamp     = {$urandom, $urandom};
      r.wait_idle = 1'b0;
      r.phase     = 2'd0;
      return r;
   endfunction

   function automatic book_req_type level_write(input logic s, input logic [4:0] ix,
                                                input logic [31:0] px,
                                                input logic [30:0] lots);
      book_req_type r;
      r        = any_beat();
      r.func   = obsf_pkg::FUNC_WRITE;
      r.side   = s;
      r.idx    = ix;
      r.lprice = px;
      r.lqty   = lots;
      return r;
   endfunction

   function automatic book_req_type depth_set(input logic s, input logic [4:0] n);
      book_req_type r;
      r      = any_beat();
      r.func = obsf_pkg::FUNC_DEPTH;
      r.side = s;
      r.idx  = n;
      return r;
   endfunction

   function automatic book_req_type order_exec(input logic s, input logic [30:0] q,
                                               input logic lim_on, input logic [31:0] lim);
      book_req_type r;
      r        = any_beat();
      r.func   = obsf_pkg::FUNC_EXEC;
      r.side   = s;
      r.oqty   = q;
      r.is_lim = lim_on;
      r.lim    = lim;
      return r;
   endfunction

   // Prices cluster so that limits land between levels; some are zero or wide.
   function automatic logic [31:0] book_price();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r == 0) return 32'd0;
      if (r == 1) return $urandom;
      return 32'd1000 + 32'($urandom_range(0, 200));
   endfunction

   function automatic logic [30:0] book_lots();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 2) return 31'd0;
      if (r == 2) return 31'($urandom);
      return 31'($urandom_range(1, 40));
   endfunction

   function automatic logic [30:0] order_lots();
      int unsigned r;
      r = $urandom_range(0, 11);
      if (r == 0) return 31'd0;
      if (r == 1) return 31'($urandom);
      return 31'($urandom_range(1, 120));
   endfunction

   task automatic stage(input book_req_type r);
      r.phase     = gen_phase;
      r.wait_idle = drain_next;
      drain_next  = 1'b0;
      if (r.func == obsf_pkg::FUNC_WRITE && r.idx < LEVELS)
         levels_written[r.side][r.idx[3:0]] = 1'b1;
      if (!(r.func == obsf_pkg::FUNC_NONE ||
            (r.func == obsf_pkg::FUNC_WRITE && r.idx >= LEVELS)))
         useful_staged++;
      req_backlog = {req_backlog, r};
      staged_total++;
   endtask

   // A depth set never exposes a level whose contents were never written.
   task automatic stage_depth(input logic s, input logic [4:0] n);
      int unsigned upto;
      upto = (n > LEVELS) ? LEVELS : n;
      for (int i = 0; i < upto; i++) begin
         if (!levels_written[s][i])
            stage(level_write(s, 5'(i), book_price(), book_lots()));
      end
      stage(depth_set(s, n));
   endtask

   // Update the book copy with one accepted beat and queue the fills it owes.
   task automatic apply_to_book(input book_req_type it);
      int unsigned   left;
      int unsigned   take;
      logic [31:0]   p;
      logic [30:0]   q;
      fill_beat_type held;
      fill_beat_type b;
      logic          have;
      case (it.func)
         obsf_pkg::FUNC_WRITE: begin
            if (it.idx < LEVELS) begin
               shadow_px[it.side][it.idx[3:0]]   = it.lprice;
               shadow_lots[it.side][it.idx[3:0]] = it.lqty;
               n_book++;
            end else begin
               n_ignored++;
            end
         end
         obsf_pkg::FUNC_DEPTH: begin
            shadow_depth[it.side] = (it.idx > LEVELS) ? LEVELS : int'(it.idx);
            n_book++;
         end
         obsf_pkg::FUNC_EXEC: begin
            n_exec++;
            left = it.oqty;
            have = 1'b0;
            b.valid = 1'b1;
            b.oid   = it.oid;
            b.sym   = it.sym;
            b.stamp = it.stamp;
            b.last  = 1'b0;
            held    = b;
            // Buy walks asks, sell walks bids, best level first.
            for (int i = 0; i < shadow_depth[it.side] && left != 0; i++) begin
               p = shadow_px[it.side][i];
               q = shadow_lots[it.side][i];
               if (it.is_lim && ((!it.side && p > it.lim) || (it.side && p < it.lim)))
                  break;
               if (q == 0)
                  continue;
               take = (int'(q) < left) ? int'(q) : left;
               b.qty = it.side ? 32'd0 - 32'(take) : 32'(take);
               b.px  = (p != 0) ? p : it.refp;
               if (have)
                  expected_fills = {expected_fills, held};
               held = b;
               have = 1'b1;
               left -= take;
               n_fills++;
            end
            // Nothing traded: a single completion marker.
            if (!have) begin
               held.valid = 1'b0;
               held.qty   = 32'd0;
               held.px    = 32'd0;
               n_nofill++;
            end
            held.last = 1'b1;
            expected_fills = {expected_fills, held};
         end
         default: n_ignored++;
      endcase
   endtask

   task automatic check_field(input string what, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                  $time, what, want, got);
      end
   endtask

   // Request driver: presents backlog beats, idling at random per phase.
   always @(posedge clock) begin : drive_req
      logic offer;
      int   tx_idle;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         offer   = req_tvalid;
         tx_idle = (idle_phase == 2'd0) ? 31 : (idle_phase == 2'd1) ? 45 : 0;
         if (req_tvalid && req_tready) begin
            apply_to_book(in_flight);
            accepted_count++;
            idle_phase <= in_flight.phase;
            offer = 1'b0;
         end
         if (!offer && req_backlog.size() != 0
             && !(req_backlog[0].wait_idle && expected_fills.size() != 0)
             && $urandom_range(0, 99) >= tx_idle) begin
            in_flight = req_backlog.pop_front();
            req_tdata <= {3'b000, in_flight.stamp, in_flight.refp, in_flight.lim,
                          in_flight.is_lim, in_flight.oqty, in_flight.sym, in_flight.oid,
                          in_flight.lqty, in_flight.lprice, in_flight.idx, in_flight.side};
            req_tuser <= in_flight.func;
            offer = 1'b1;
         end
         req_tvalid <= offer;
      end
   end

   // Long result hold-off once the no-idle phase starts.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && idle_phase == 2'd2) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Result monitor: compares each accepted beat with the oldest expectation.
   always @(posedge clock) begin : watch_rsp
      fill_beat_type want;
      int            rx_idle;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rx_idle = (idle_phase == 2'd0) ? 45 : (idle_phase == 2'd1) ? 31 : 0;
         if (rsp_tvalid && rsp_tready) begin
            if (expected_fills.size() == 0) begin
               errors++;
               $display("%0t ns: unexpected result beat, expected none, actual 0x%0h",
                        $time, rsp_tdata);
            end else begin
               want = expected_fills.pop_front();
               check_field("fill_valid", 64'(want.valid), 64'(rsp_tuser[0]));
               check_field("fill_ord_num", 64'(want.oid), 64'(rsp_tdata[31:0]));
               check_field("fill_symbol", 64'(want.sym), 64'(rsp_tdata[47:32]));
               check_field("fill_qty", 64'(want.qty), 64'(rsp_tdata[79:48]));
               check_field("fill_price", 64'(want.px), 64'(rsp_tdata[111:80]));
               check_field("fill_time", want.stamp, rsp_tdata[175:112]);
               check_field("last", 64'(want.last), 64'(rsp_tlast));
            end
         end
         rsp_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= rx_idle);
      end
   end

   initial begin
      logic        s;
      int unsigned pick;
      int          base;
      int          done;
      logic        second_drain;

      levels_written[0] = '0;
      levels_written[1] = '0;
      second_drain      = 1'b0;

      // Directed: empty side, unused code, book edges, limits and the zero price.
      stage(order_exec(1'b0, 31'd5, 1'b0, 32'd0));
      stage(any_beat());
      stage(level_write(1'b0, 5'd0, 32'd1000, 31'd1));
      stage(level_write(1'b0, 5'd1, 32'd0, 31'd2));
      stage(level_write(1'b0, 5'd2, 32'd1020, 31'd0));
      stage(level_write(1'b0, 5'd3, 32'd1030, 31'd4));
      stage(level_write(1'b0, 5'd4, 32'd1040, 31'd5));
      stage(level_write(1'b0, 5'd5, 32'hFFFF_FFFF, 31'h7FFF_FFFF));
      stage(level_write(1'b0, 5'd16, $urandom, 31'($urandom)));
      stage(level_write(1'b1, 5'd31, $urandom, 31'($urandom)));
      stage_depth(1'b0, 5'd6);
      stage(order_exec(1'b0, 31'd0, 1'b0, 32'd0));
      stage(order_exec(1'b0, 31'h7FFF_FFFF, 1'b0, 32'd0));
      stage(order_exec(1'b0, 31'd50, 1'b1, 32'd999));
      stage(order_exec(1'b0, 31'd3, 1'b1, 32'd1000));
      stage(order_exec(1'b0, 31'd1000, 1'b1, 32'd1040));
      stage(level_write(1'b1, 5'd0, 32'd2000, 31'd0));
      stage(level_write(1'b1, 5'd1, 32'd1990, 31'd4));
      stage(level_write(1'b1, 5'd2, 32'd0, 31'd6));
      stage_depth(1'b1, 5'd2);
      stage(order_exec(1'b1, 31'd10, 1'b0, 32'd0));
      stage_depth(1'b1, 5'd1);
      stage(order_exec(1'b1, 31'd10, 1'b0, 32'd0));
      stage_depth(1'b1, 5'd3);
      stage(order_exec(1'b1, 31'd50, 1'b1, 32'd1995));
      stage(order_exec(1'b1, 31'd8, 1'b1, 32'd0));

      // Random: open with a drained, oversized depth set on a full side.
      drain_next = 1'b1;
      stage_depth(1'($urandom), 5'($urandom_range(17, 31)));
      base = useful_staged;
      while (useful_staged - base < RANDOM_ITEMS) begin
         done      = useful_staged - base;
         gen_phase = (done < RANDOM_ITEMS / 3) ? 2'd0 :
                     (done < 2 * RANDOM_ITEMS / 3) ? 2'd1 : 2'd2;
         if (done >= (5 * RANDOM_ITEMS) / 6 && !second_drain) begin
            drain_next   = 1'b1;
            second_drain = 1'b1;
         end
         s    = 1'($urandom);
         pick = $urandom_range(0, 99);
         if (pick < 30)
            stage(level_write(s, ($urandom_range(0, 9) == 0) ? 5'($urandom_range(16, 31))
                                                            : 5'($urandom_range(0, 15)),
                              book_price(), book_lots()));
         else if (pick < 42)
            stage_depth(s, ($urandom_range(0, 4) == 0) ? 5'($urandom_range(17, 31))
                                                       : 5'($urandom_range(0, 16)));
         else if (pick < 97)
            stage(order_exec(s, order_lots(), 1'($urandom), book_price()));
         else
            stage(any_beat());
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Drain: all beats sent, all fills back, then a settle window.
      while (accepted_count < staged_total) @(posedge clock);
      while (expected_fills.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("Run covered %0d orders (%0d fills, %0d no-fill markers),",
               n_exec, n_fills, n_nofill);
      $display("%0d book updates and %0d ignored beats under random and long stalls.",
               n_book, n_ignored);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #2_000_000;
      $display("Timeout with %0d fills still expected.", expected_fills.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule

@@ filelist.f @@
hdl/obsf_pkg.sv
hdl/obsf_ram.sv
hdl/obsf_datapath.sv
hdl/obsf_ctrl.sv
hdl/order_book_sweep_fill.sv
tb/testbench.sv
